### rtl/binary_min_heap_queue_top_macros.svh
// ----------------------------------------------------------------------------
// heap queue assertion macros
// shared concurrent check shorthands, sampled on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BMHQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication
`define BMHQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`else

`define BMHQ_ASSERT_IMP(lbl, ante, cons)
`define BMHQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// heap queue package
// sizes, operation and status codes and the stored entry type
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // heap sizing
    localparam int DEPTH        = 128;
    localparam int KEY_BITS     = 16;
    localparam int TAG_BITS     = 16;
    localparam int ADDR_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int CHILD_BITS   = ADDR_BITS + 2;
    localparam int ENTRIES_BITS = 8;
    localparam int STATUS_BITS  = 2;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // one heap slot
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage

### rtl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary min-heap priority queue
// array heap of key/tag items in one ram, sifted by a small sequencer
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows for
// one cycle with done high and cannot be held off. Every item in the ram is
// touched through one read port and one key comparator: an insert compares
// with the parent once per level climbed, and a remove reads the left child,
// reads the right child and decides once per level dropped. A rejected insert
// or remove touches no slot. The next item may be started in the cycle done
// is high. Ties on key keep the fixed sift order, so equal keys leave in a
// defined tag order.
`include "binary_min_heap_queue_top_macros.svh"

module binary_min_heap_queue_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [bmhq_pkg::KEY_BITS-1:0]       key,
    input  logic [bmhq_pkg::TAG_BITS-1:0]       tag,
    output logic                                done,
    output logic [bmhq_pkg::STATUS_BITS-1:0]    status,
    output logic [bmhq_pkg::KEY_BITS-1:0]       out_key,
    output logic [bmhq_pkg::TAG_BITS-1:0]       out_tag,
    output logic [bmhq_pkg::ENTRIES_BITS-1:0]   entries,
    output logic                                is_empty
);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_UP_CMP    = 3'd1;
    localparam logic [2:0] S_RM_ROOT   = 3'd2;
    localparam logic [2:0] S_RM_LAST   = 3'd3;
    localparam logic [2:0] S_DN_LEFT   = 3'd4;
    localparam logic [2:0] S_DN_RIGHT  = 3'd5;
    localparam logic [2:0] S_DN_DECIDE = 3'd6;
    localparam logic [2:0] S_PUT       = 3'd7;

    logic [2:0]                          state_reg, state_next;
    logic [bmhq_pkg::CNT_BITS-1:0]       count_reg, count_next;
    logic                                done_reg, done_next;
    logic [bmhq_pkg::ADDR_BITS-1:0]      pos_reg, pos_next;
    bmhq_pkg::entry_t                    cur_reg, cur_next;
    bmhq_pkg::entry_t                    side_reg, side_next;
    logic                                pick_right_reg, pick_right_next;
    logic [bmhq_pkg::STATUS_BITS-1:0]    status_reg, status_next;
    bmhq_pkg::entry_t                    out_reg, out_next;

    logic                                ram_we;
    logic [bmhq_pkg::ADDR_BITS-1:0]      ram_waddr;
    bmhq_pkg::entry_t                    ram_wdata;
    logic                                ram_re;
    logic [bmhq_pkg::ADDR_BITS-1:0]      ram_raddr;
    bmhq_pkg::entry_t                    ram_rdata;

    logic [bmhq_pkg::KEY_BITS-1:0]       cmp_a;
    logic [bmhq_pkg::KEY_BITS-1:0]       cmp_b;
    logic                                lt;

    logic [bmhq_pkg::ADDR_BITS-1:0]      up_parent;
    logic [bmhq_pkg::CHILD_BITS-1:0]     left_idx;
    logic [bmhq_pkg::CHILD_BITS-1:0]     right_idx;
    logic [bmhq_pkg::CHILD_BITS-1:0]     count_ext;
    logic [bmhq_pkg::ADDR_BITS-1:0]      dn_child;
    logic [bmhq_pkg::CHILD_BITS-1:0]     dn_next_left;
    bmhq_pkg::entry_t                    in_item;
    logic                                heap_full;
    logic                                insert_ok;

    // parent slot of a heap position
    function automatic logic [bmhq_pkg::ADDR_BITS-1:0] parent_of(
        input logic [bmhq_pkg::ADDR_BITS-1:0] p
    );
        logic [bmhq_pkg::ADDR_BITS-1:0] pm;
        pm = p - 1'b1;
        return pm >> 1;
    endfunction

    // left child index, wide enough to run past the end
    function automatic logic [bmhq_pkg::CHILD_BITS-1:0] left_of(
        input logic [bmhq_pkg::ADDR_BITS-1:0] p
    );
        return {1'b0, p, 1'b1};
    endfunction

    // heap storage
    bmhq_ram #(
        .WIDTH (bmhq_pkg::ENTRY_BITS),
        .DEPTH (bmhq_pkg::DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // index helpers
    assign in_item      = '{key: key, tag: tag};
    assign up_parent    = parent_of(pos_reg);
    assign left_idx     = left_of(pos_reg);
    assign right_idx    = left_idx + 1'b1;
    assign count_ext    = bmhq_pkg::CHILD_BITS'(count_reg);
    assign dn_child     = pick_right_reg ? right_idx[bmhq_pkg::ADDR_BITS-1:0]
                                         : left_idx[bmhq_pkg::ADDR_BITS-1:0];
    assign dn_next_left = left_of(dn_child);
    assign heap_full    = count_reg == bmhq_pkg::CNT_BITS'(bmhq_pkg::DEPTH);
    assign insert_ok    = start && !busy && (opcode == bmhq_pkg::OP_INSERT) && !heap_full;

    // shared key comparator
    always_comb
    begin
        case (state_reg)
            S_DN_RIGHT:
            begin
                cmp_a = ram_rdata.key;
                cmp_b = side_reg.key;
            end
            S_DN_DECIDE:
            begin
                cmp_a = side_reg.key;
                cmp_b = cur_reg.key;
            end
            default:
            begin
                cmp_a = cur_reg.key;
                cmp_b = ram_rdata.key;
            end
        endcase
    end

    assign lt = cmp_a < cmp_b;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        side_next       = side_reg;
        pick_right_next = pick_right_reg;
        status_next     = status_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = cur_reg;
        ram_re          = 1'b0;
        ram_raddr       = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    out_next    = '0;
                    status_next = bmhq_pkg::ST_OK;
                    if (opcode == bmhq_pkg::OP_INSERT)
                    begin
                        if (heap_full)
                        begin
                            status_next = bmhq_pkg::ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            cur_next   = in_item;
                            pos_next   = bmhq_pkg::ADDR_BITS'(count_reg);
                            count_next = count_reg + 1'b1;
                            if (count_reg == '0)
                            begin
                                // first item lands on the root directly
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = in_item;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = parent_of(bmhq_pkg::ADDR_BITS'(count_reg));
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = bmhq_pkg::ST_EMPTY;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = S_RM_ROOT;
                    end
                end
            end

            // sift up: parent in ram_rdata
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (lt)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = up_parent;
                    if (up_parent == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = parent_of(up_parent);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // root read back, fetch the last slot
            S_RM_ROOT:
            begin
                out_next   = ram_rdata;
                count_next = count_reg - 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = bmhq_pkg::ADDR_BITS'(count_reg - 1'b1);
                state_next = S_RM_LAST;
            end

            // last entry becomes the moving item at the root
            S_RM_LAST:
            begin
                cur_next = ram_rdata;
                pos_next = '0;
                if (count_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (left_of('0) < count_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = bmhq_pkg::ADDR_BITS'(1);
                    state_next = S_DN_LEFT;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            // left child in ram_rdata
            S_DN_LEFT:
            begin
                side_next       = ram_rdata;
                pick_right_next = 1'b0;
                if (right_idx < count_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = right_idx[bmhq_pkg::ADDR_BITS-1:0];
                    state_next = S_DN_RIGHT;
                end
                else
                begin
                    state_next = S_DN_DECIDE;
                end
            end

            // right child wins only when strictly smaller
            S_DN_RIGHT:
            begin
                if (lt)
                begin
                    side_next       = ram_rdata;
                    pick_right_next = 1'b1;
                end
                state_next = S_DN_DECIDE;
            end

            // swap down while the chosen child is strictly smaller
            S_DN_DECIDE:
            begin
                ram_we = 1'b1;
                if (lt)
                begin
                    ram_wdata = side_reg;
                    pos_next  = dn_child;
                    if (dn_next_left < count_ext)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = dn_next_left[bmhq_pkg::ADDR_BITS-1:0];
                        state_next = S_DN_LEFT;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // moving item into its final slot
            S_PUT:
            begin
                ram_we     = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        side_reg       <= side_next;
        pick_right_reg <= pick_right_next;
        status_reg     <= status_next;
        out_reg        <= out_next;
    end

    // outputs
    assign busy     = state_reg != S_IDLE;
    assign done     = done_reg;
    assign status   = status_reg;
    assign out_key  = out_reg.key;
    assign out_tag  = out_reg.tag;
    assign entries  = bmhq_pkg::ENTRIES_BITS'(count_reg);
    assign is_empty = count_reg == '0;

    // checks
    `BMHQ_ASSERT_IMP(a_count_range, 1'b1, count_reg <= bmhq_pkg::CNT_BITS'(bmhq_pkg::DEPTH))
    `BMHQ_ASSERT_IMP(a_done_idle, done_reg, !busy)
    `BMHQ_ASSERT_IMP(a_wr_in_heap, ram_we, bmhq_pkg::CNT_BITS'(ram_waddr) < count_next)
    `BMHQ_ASSERT_IMP(a_empty_status, done_reg && (status_reg == bmhq_pkg::ST_EMPTY), is_empty)
    `BMHQ_ASSERT_NXT(a_insert_grows, insert_ok, count_reg == $past(count_reg) + 1'b1)

endmodule

### tb/binary_min_heap_queue_checker.sv
// ----------------------------------------------------------------------------
// heap queue checker
// watches the item and result channels of the heap queue, keeps its own
// array heap to work out each result and compares every field in order
// ----------------------------------------------------------------------------
module binary_min_heap_queue_checker
    import bmhq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     opcode,
    input  logic [KEY_BITS-1:0]      key,
    input  logic [TAG_BITS-1:0]      tag,
    input  logic                     done,
    input  logic [STATUS_BITS-1:0]   status,
    input  logic [KEY_BITS-1:0]      out_key,
    input  logic [TAG_BITS-1:0]      out_tag,
    input  logic [ENTRIES_BITS-1:0]  entries,
    input  logic                     is_empty,
    output int                       fail_count,
    output int                       owed_count,
    output int                       full_rejects,
    output int                       empty_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [KEY_BITS-1:0]     key;
        logic [TAG_BITS-1:0]     tag;
        logic [ENTRIES_BITS-1:0] entries;
        logic                    empty;
    } heap_result_t;

    // mirror of the heap contents
    logic [KEY_BITS-1:0] heap_key [DEPTH];
    logic [TAG_BITS-1:0] heap_tag [DEPTH];
    int                  heap_cnt = 0;

    heap_result_t owed_results [$];
    int           owed = 0;
    int           fails = 0;
    int           full_seen = 0;
    int           empty_seen = 0;

    assign fail_count    = fails;
    assign owed_count    = owed;
    assign full_rejects  = full_seen;
    assign empty_rejects = empty_seen;

    function automatic void swap_slots(input int a, input int b);
        logic [KEY_BITS-1:0] k;
        logic [TAG_BITS-1:0] t;
        k           = heap_key[a];
        t           = heap_tag[a];
        heap_key[a] = heap_key[b];
        heap_tag[a] = heap_tag[b];
        heap_key[b] = k;
        heap_tag[b] = t;
    endfunction

    // one insert or remove on the mirror heap, returns the result it owes
    function automatic heap_result_t apply_heap_op(
        input logic                op,
        input logic [KEY_BITS-1:0] k,
        input logic [TAG_BITS-1:0] t
    );
        heap_result_t r;
        int           pos;
        int           parent;
        int           left;
        int           pick;
        bit           moving;
        r = '0;
        if (op == OP_INSERT)
        begin
            if (heap_cnt >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // append, then climb while strictly smaller than the parent
                pos           = heap_cnt;
                heap_key[pos] = k;
                heap_tag[pos] = t;
                heap_cnt      = heap_cnt + 1;
                moving        = 1'b1;
                while (moving && pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (heap_key[pos] < heap_key[parent])
                    begin
                        swap_slots(pos, parent);
                        pos = parent;
                    end
                    else
                    begin
                        moving = 1'b0;
                    end
                end
            end
        end
        else
        begin
            if (heap_cnt == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                // take the root, move the last entry up and sink it
                r.key       = heap_key[0];
                r.tag       = heap_tag[0];
                heap_cnt    = heap_cnt - 1;
                heap_key[0] = heap_key[heap_cnt];
                heap_tag[0] = heap_tag[heap_cnt];
                pos         = 0;
                moving      = 1'b1;
                while (moving && 2 * pos + 1 < heap_cnt)
                begin
                    left = 2 * pos + 1;
                    pick = left;
                    // right child only when strictly smaller than the left
                    if (left + 1 < heap_cnt && heap_key[left + 1] < heap_key[left])
                        pick = left + 1;
                    if (heap_key[pos] > heap_key[pick])
                    begin
                        swap_slots(pos, pick);
                        pos = pick;
                    end
                    else
                    begin
                        moving = 1'b0;
                    end
                end
            end
        end
        r.entries = ENTRIES_BITS'(heap_cnt);
        r.empty   = (heap_cnt == 0);
        return r;
    endfunction

    // compare each result with the oldest owed one, then log new items
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result with no item outstanding");
                fails = fails + 1;
            end
            else
            begin
                want = owed_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fails = fails + 1;
                end
                if (out_key !== want.key)
                begin
                    $error("out_key: expected %0h, got %0h", want.key, out_key);
                    fails = fails + 1;
                end
                if (out_tag !== want.tag)
                begin
                    $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
                    fails = fails + 1;
                end
                if (entries !== want.entries)
                begin
                    $error("entries: expected %0d, got %0d", want.entries, entries);
                    fails = fails + 1;
                end
                if (is_empty !== want.empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.empty, is_empty);
                    fails = fails + 1;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            want = apply_heap_op(opcode, key, tag);
            if (want.status == ST_FULL)
                full_seen = full_seen + 1;
            if (want.status == ST_EMPTY)
                empty_seen = empty_seen + 1;
            owed_results.push_back(want);
        end
        owed = owed_results.size();
    end

endmodule

### tb/tb_binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// heap queue testbench
// directed corner items then phases of fill, drain and mixed traffic with
// random gaps; the checker predicts and compares, this top gives the verdict
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue_top;
    import bmhq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    opcode;
    logic [KEY_BITS-1:0]     key;
    logic [TAG_BITS-1:0]     tag;
    logic                    done;
    logic [STATUS_BITS-1:0]  status;
    logic [KEY_BITS-1:0]     out_key;
    logic [TAG_BITS-1:0]     out_tag;
    logic [ENTRIES_BITS-1:0] entries;
    logic                    is_empty;

    int fail_count;
    int owed_count;
    int full_rejects;
    int empty_rejects;
    int inserts_sent = 0;
    int removes_sent = 0;

    binary_min_heap_queue_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .key      (key),
        .tag      (tag),
        .done     (done),
        .status   (status),
        .out_key  (out_key),
        .out_tag  (out_tag),
        .entries  (entries),
        .is_empty (is_empty)
    );

    binary_min_heap_queue_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .key           (key),
        .tag           (tag),
        .done          (done),
        .status        (status),
        .out_key       (out_key),
        .out_tag       (out_tag),
        .entries       (entries),
        .is_empty      (is_empty),
        .fail_count    (fail_count),
        .owed_count    (owed_count),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("[binary_min_heap_queue_top] ERROR");
        $finish;
    end

    // present one item after a gap and hold it until taken
    task automatic send_item(input logic op, input logic [KEY_BITS-1:0] k,
                             input logic [TAG_BITS-1:0] t, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        opcode <= op;
        key    <= k;
        tag    <= t;
        do @(posedge clk); while (busy);
        if (op == OP_INSERT)
            inserts_sent = inserts_sent + 1;
        else
            removes_sent = removes_sent + 1;
    endtask

    // keys lean toward a few small values so ties are common
    function automatic logic [KEY_BITS-1:0] draw_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return KEY_BITS'($urandom_range(0, 7));
        else if (pick == 4)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        else
            return KEY_BITS'($urandom());
    endfunction

    // stimulus
    initial
    begin
        int  total;
        int  phase_len;
        int  insert_pct;
        int  mode;
        bit  idle_on;
        logic op;

        rst_n  = 1'b0;
        start  = 1'b0;
        opcode = OP_INSERT;
        key    = '0;
        tag    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, key and tag extremes, equal keys
        send_item(OP_REMOVE, 16'h0000, 16'h0000, 0);
        send_item(OP_INSERT, 16'hffff, 16'h0000, 0);
        send_item(OP_INSERT, 16'h0000, 16'hffff, 1);
        send_item(OP_INSERT, 16'h8000, 16'h1234, 0);
        send_item(OP_INSERT, 16'h0005, 16'h0001, 0);
        send_item(OP_INSERT, 16'h0005, 16'h0002, 2);
        send_item(OP_INSERT, 16'h0005, 16'h0003, 0);
        send_item(OP_INSERT, 16'h0005, 16'h0004, 0);
        send_item(OP_INSERT, 16'h5555, 16'haaaa, 3);
        send_item(OP_INSERT, 16'haaaa, 16'h5555, 0);
        send_item(OP_INSERT, 16'h0005, 16'haaaa, 0);
        repeat (10) send_item(OP_REMOVE, 16'hffff, 16'hffff, $urandom_range(0, 1));
        send_item(OP_REMOVE, 16'h0000, 16'h0000, 0);
        total = 22;

        // random phases: first a fill past full and a drain past empty
        mode = 0;
        while (total < 1000)
        begin
            if (mode == 0)
            begin
                phase_len  = DEPTH + 12;
                insert_pct = 100;
            end
            else if (mode == 1)
            begin
                phase_len  = DEPTH + 12;
                insert_pct = 0;
            end
            else
            begin
                phase_len = $urandom_range(20, 150);
                case ($urandom_range(0, 3))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    2:       insert_pct = 80;
                    default: insert_pct = 95;
                endcase
            end
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (phase_len)
            begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                send_item(op, draw_key(), TAG_BITS'($urandom()),
                          idle_on ? $urandom_range(0, 9) : 0);
                total = total + 1;
            end
            mode = mode + 1;
        end
        start <= 1'b0;

        // drain outstanding results, then allow for the longest item
        while (owed_count != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("%0d items: %0d inserts, %0d removes", total, inserts_sent, removes_sent);
        $display("full heap rejects %0d, empty heap rejects %0d", full_rejects,
                 empty_rejects);
        if (fail_count == 0)
            $display("[binary_min_heap_queue_top] OK");
        else
            $display("[binary_min_heap_queue_top] ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/binary_min_heap_queue_top.sv
tb/binary_min_heap_queue_checker.sv
tb/tb_binary_min_heap_queue_top.sv
